>>> src/lbcp_pkg.sv
// ----------------------------------------------------------------------------
// lbcp_pkg
// Shared types and constants for the layered box collision pair finder.
// ----------------------------------------------------------------------------
package lbcp_pkg;

   localparam int COORD_W = 16;
   localparam int SIZE_W  = 15;
   localparam int LAYER_W = 2;
   localparam int IDX_OUT_W = 5;

   // Box record layout, identical on req_tdata and in the box store
   localparam int X_LSB     = 0;
   localparam int Y_LSB     = 16;
   localparam int W_LSB     = 32;
   localparam int H_LSB     = 47;
   localparam int Z_LSB     = 62;
   localparam int L_LSB     = 78;
   localparam int BOX_W     = 80;

   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_USER_W = 2;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam int MATRIX_W   = 16;
   localparam int TOL_W      = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_LAYER_MATRIX = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH_TOL    = 1'd1;

   localparam logic [MATRIX_W-1:0] LAYER_MATRIX_RST = 16'd1878;
   localparam logic [TOL_W-1:0]    DEPTH_TOL_RST    = 8'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic scan;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic scan_done;
      logic out_free;
   } status_type;

endpackage

>>> src/lbcp_ctrl.sv
// ----------------------------------------------------------------------------
// lbcp_ctrl
// Sequencer: accept a box, scan the store, then emit the closing result.
// ----------------------------------------------------------------------------
module lbcp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  lbcp_pkg::status_type   sts,
   output lbcp_pkg::cmd_type      cmd
);

   lbcp_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lbcp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         lbcp_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = lbcp_pkg::ST_SCAN;
            end
         end
         lbcp_pkg::ST_SCAN: begin
            priority if (sts.full) begin
               state_in = lbcp_pkg::ST_FINISH;
            end else if (sts.scan_done) begin
               state_in = lbcp_pkg::ST_FINISH;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         lbcp_pkg::ST_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = lbcp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lbcp_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> src/lbcp_datapath.sv
// ----------------------------------------------------------------------------
// lbcp_datapath
// Box store, stallable one-compare-per-cycle pair test, pending hit and result register.
// ----------------------------------------------------------------------------
module lbcp_datapath #(
   parameter int MAX_BOXES = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [lbcp_pkg::BOX_W-1:0]          req_tdata,
   input  logic [lbcp_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lbcp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [lbcp_pkg::RSP_USER_W-1:0]     rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   input  logic [lbcp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lbcp_pkg::CSR_DATA_W-1:0]     csr_data,
   input  lbcp_pkg::cmd_type                   cmd,
   output lbcp_pkg::status_type                sts
);

   localparam int IW = $clog2(MAX_BOXES);
   localparam int CW = $clog2(MAX_BOXES + 1);
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_BOXES);
   localparam int OW = lbcp_pkg::IDX_OUT_W;

   logic [lbcp_pkg::BOX_W-1:0] mem [MAX_BOXES];

   logic [lbcp_pkg::MATRIX_W-1:0] matrix_ff;
   logic [lbcp_pkg::TOL_W-1:0]    tol_ff;
   logic [lbcp_pkg::BOX_W-1:0]    new_box_ff;
   logic [lbcp_pkg::BOX_W-1:0]    rd_data_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_ptr_ff, rd_ptr_in;
   logic          cmp_valid_ff, cmp_valid_in;
   logic [IW-1:0] cmp_idx_ff, cmp_idx_in;
   logic          pend_valid_ff, pend_valid_in;
   logic [IW-1:0] pend_idx_ff, pend_idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_found_ff, rsp_found_in;
   logic          rsp_dropped_ff, rsp_dropped_in;
   logic          rsp_last_ff, rsp_last_in;
   logic [OW-1:0] rsp_earlier_ff, rsp_earlier_in;
   logic [OW-1:0] rsp_newer_ff, rsp_newer_in;

   logic          full, out_free, hit, stall, advance, rd_en, wr_en, out_load;
   logic [OW-1:0] count_out, pend_out;

   // pair test on the stored box held in the read register
   logic signed [15:0] sx, sy, sz, nx, ny, nz;
   logic [14:0]        sw, sh, nw, nh;
   logic [1:0]         sl, nl;
   logic signed [17:0] s_right, s_bottom, n_right, n_bottom;
   logic [16:0]        abs_s, abs_n;
   logic signed [17:0] depth_diff;
   logic               layer_ok, depth_ok, overlap;

   always_comb begin
      sx = rd_data_ff[lbcp_pkg::X_LSB +: lbcp_pkg::COORD_W];
      sy = rd_data_ff[lbcp_pkg::Y_LSB +: lbcp_pkg::COORD_W];
      sw = rd_data_ff[lbcp_pkg::W_LSB +: lbcp_pkg::SIZE_W];
      sh = rd_data_ff[lbcp_pkg::H_LSB +: lbcp_pkg::SIZE_W];
      sz = rd_data_ff[lbcp_pkg::Z_LSB +: lbcp_pkg::COORD_W];
      sl = rd_data_ff[lbcp_pkg::L_LSB +: lbcp_pkg::LAYER_W];
      nx = new_box_ff[lbcp_pkg::X_LSB +: lbcp_pkg::COORD_W];
      ny = new_box_ff[lbcp_pkg::Y_LSB +: lbcp_pkg::COORD_W];
      nw = new_box_ff[lbcp_pkg::W_LSB +: lbcp_pkg::SIZE_W];
      nh = new_box_ff[lbcp_pkg::H_LSB +: lbcp_pkg::SIZE_W];
      nz = new_box_ff[lbcp_pkg::Z_LSB +: lbcp_pkg::COORD_W];
      nl = new_box_ff[lbcp_pkg::L_LSB +: lbcp_pkg::LAYER_W];

      s_right  = 18'(sx) + $signed({3'b000, sw});
      s_bottom = 18'(sy) + $signed({3'b000, sh});
      n_right  = 18'(nx) + $signed({3'b000, nw});
      n_bottom = 18'(ny) + $signed({3'b000, nh});
      overlap  = !((s_right < 18'(nx)) || (n_right < 18'(sx)) ||
                   (n_bottom < 18'(sy)) || (s_bottom < 18'(ny)));

      abs_s = sz[15] ? (17'd0 - {1'b1, sz}) : {1'b0, sz};
      abs_n = nz[15] ? (17'd0 - {1'b1, nz}) : {1'b0, nz};
      depth_diff = $signed({1'b0, abs_s}) - $signed({1'b0, abs_n});
      depth_ok   = depth_diff <= $signed({10'd0, tol_ff});

      layer_ok = matrix_ff[{sl, nl}];
      hit      = cmp_valid_ff && layer_ok && depth_ok && overlap;
   end

   always_comb begin
      full      = count_ff == MAX_COUNT;
      out_free  = !rsp_valid_ff || rsp_tready;
      stall     = hit && pend_valid_ff && !out_free;
      advance   = cmd.scan && !stall;
      rd_en     = advance && (rd_ptr_ff < count_ff);
      wr_en     = cmd.finish && !full;
      count_out = OW'({{OW{1'b0}}, count_ff});
      pend_out  = OW'({{OW{1'b0}}, pend_idx_ff});

      sts.full      = full;
      sts.scan_done = (rd_ptr_ff == count_ff) && !cmp_valid_ff;
      sts.out_free  = out_free;

      count_in       = count_ff;
      rd_ptr_in      = rd_ptr_ff;
      cmp_valid_in   = cmp_valid_ff;
      cmp_idx_in     = cmp_idx_ff;
      pend_valid_in  = pend_valid_ff;
      pend_idx_in    = pend_idx_ff;
      out_load       = 1'b0;
      rsp_found_in   = rsp_found_ff;
      rsp_dropped_in = rsp_dropped_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_earlier_in = rsp_earlier_ff;
      rsp_newer_in   = rsp_newer_ff;

      if (cmd.accept) begin
         if (req_tuser[0]) begin
            count_in = '0;
         end
         rd_ptr_in     = '0;
         cmp_valid_in  = 1'b0;
         pend_valid_in = 1'b0;
      end

      if (advance) begin
         cmp_valid_in = rd_en;
         cmp_idx_in   = rd_ptr_ff[IW-1:0];
         if (rd_en) begin
            rd_ptr_in = rd_ptr_ff + CW'(1);
         end
         if (hit) begin
            pend_valid_in = 1'b1;
            pend_idx_in   = cmp_idx_ff;
            if (pend_valid_ff) begin
               out_load       = 1'b1;
               rsp_found_in   = 1'b1;
               rsp_dropped_in = 1'b0;
               rsp_last_in    = 1'b0;
               rsp_earlier_in = pend_out;
               rsp_newer_in   = count_out;
            end
         end
      end

      if (cmd.finish) begin
         out_load      = 1'b1;
         pend_valid_in = 1'b0;
         rsp_last_in   = 1'b1;
         priority if (full) begin
            rsp_found_in   = 1'b0;
            rsp_dropped_in = 1'b1;
            rsp_earlier_in = '0;
            rsp_newer_in   = '0;
         end else if (pend_valid_ff) begin
            rsp_found_in   = 1'b1;
            rsp_dropped_in = 1'b0;
            rsp_earlier_in = pend_out;
            rsp_newer_in   = count_out;
         end else begin
            rsp_found_in   = 1'b0;
            rsp_dropped_in = 1'b0;
            rsp_earlier_in = '0;
            rsp_newer_in   = count_out;
         end
         if (!full) begin
            count_in = count_ff + CW'(1);
         end
      end

      rsp_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff     <= lbcp_pkg::LAYER_MATRIX_RST;
         tol_ff        <= lbcp_pkg::DEPTH_TOL_RST;
         count_ff      <= '0;
         rd_ptr_ff     <= '0;
         cmp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               lbcp_pkg::CSR_LAYER_MATRIX: matrix_ff <= csr_data;
               lbcp_pkg::CSR_DEPTH_TOL:    tol_ff    <= csr_data[lbcp_pkg::TOL_W-1:0];
               default: ;
            endcase
         end
         count_ff      <= count_in;
         rd_ptr_ff     <= rd_ptr_in;
         cmp_valid_ff  <= cmp_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff     <= cmp_idx_in;
      pend_idx_ff    <= pend_idx_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_dropped_ff <= rsp_dropped_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_earlier_ff <= rsp_earlier_in;
      rsp_newer_ff   <= rsp_newer_in;
      if (cmd.accept) begin
         new_box_ff <= req_tdata;
      end
   end

   // box store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[IW-1:0]] <= new_box_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_ptr_ff[IW-1:0]];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(lbcp_pkg::RSP_DATA_W - 2*OW){1'b0}}, rsp_newer_ff, rsp_earlier_ff};
   assign rsp_tuser  = {rsp_dropped_ff, rsp_found_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> src/layered_box_collision_pairs.sv
// Each box transfer is followed by a scan of the N stored boxes (skipped when the
// store is full), one stored box compared per cycle through the store's single
// read port while the result register can take each hit, then by its closing result;
// the next box is taken only once that closing result is loaded; rsp_tready low delays both.
// Reset clears the box count and the result register and loads layer_matrix = 1878,
// depth_tolerance = 3; store contents are not cleared.
// ----------------------------------------------------------------------------
// layered_box_collision_pairs
// Streams boxes of a frame and reports every colliding pair with earlier boxes.
// ----------------------------------------------------------------------------
module layered_box_collision_pairs #(
   parameter int MAX_BOXES = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [15:0] left_x, [31:16] top_y, [46:32] box_width, [61:47] box_height,
   // [77:62] box_depth, [79:78] box_layer
   input  logic [lbcp_pkg::BOX_W-1:0]          req_tdata,
   // [0] first_of_frame
   input  logic [lbcp_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [4:0] earlier_index, [9:5] newer_index, [15:10] zero
   output logic [lbcp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [0] pair_found, [1] dropped
   output logic [lbcp_pkg::RSP_USER_W-1:0]     rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lbcp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lbcp_pkg::CSR_DATA_W-1:0]     csr_data
);

   lbcp_pkg::cmd_type    cmd;
   lbcp_pkg::status_type sts;

   assign csr_ready = 1'b1;

   lbcp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lbcp_datapath #(
      .MAX_BOXES (MAX_BOXES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

>>> src/lbcp_checker.sv
// ----------------------------------------------------------------------------
// lbcp_checker
// Port-level checks on request and result stream behavior, bound to the top level.
// ----------------------------------------------------------------------------
module lbcp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [lbcp_pkg::BOX_W-1:0]          req_tdata,
   input logic [lbcp_pkg::REQ_USER_W-1:0]     req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [lbcp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic [lbcp_pkg::RSP_USER_W-1:0]     rsp_tuser,
   input logic                                rsp_tlast,
   input logic                                csr_valid,
   input logic                                csr_ready,
   input logic [lbcp_pkg::CSR_IDX_W-1:0]      csr_index,
   input logic [lbcp_pkg::CSR_DATA_W-1:0]     csr_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   a_drop_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast && !rsp_tuser[0] && rsp_tdata[9:0] == 10'd0)
      else $error("dropped result not a lone closing transfer");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && rsp_tdata[4:0] == 5'd0)
      else $error("empty result not closing or has an index");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second box taken while one is in work");

endmodule

bind layered_box_collision_pairs lbcp_checker u_lbcp_checker (.*);

>>> verif/layered_box_collision_pairs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// layered_box_collision_pairs_checker
// Watches the box, result and register channels of the collision pair finder.
// It keeps its own box store and register copies, works out the pair results
// for each box transfer and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module layered_box_collision_pairs_checker #(
   parameter int MAX_BOXES = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [lbcp_pkg::BOX_W-1:0]          req_tdata,
   input  logic [lbcp_pkg::REQ_USER_W-1:0]     req_tuser,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [lbcp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic [lbcp_pkg::RSP_USER_W-1:0]     rsp_tuser,
   input  logic                                rsp_tlast,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [lbcp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lbcp_pkg::CSR_DATA_W-1:0]     csr_data,
   output int                                  mismatches,
   output int                                  pending,
   output int                                  results_seen,
   output int                                  pairs_seen,
   output int                                  drops_seen
);

   localparam int COORD_W   = lbcp_pkg::COORD_W;
   localparam int SIZE_W    = lbcp_pkg::SIZE_W;
   localparam int LAYER_W   = lbcp_pkg::LAYER_W;
   localparam int IDX_OUT_W = lbcp_pkg::IDX_OUT_W;
   localparam int MATRIX_W  = lbcp_pkg::MATRIX_W;
   localparam int TOL_W     = lbcp_pkg::TOL_W;
   localparam int X_LSB     = lbcp_pkg::X_LSB;
   localparam int Y_LSB     = lbcp_pkg::Y_LSB;
   localparam int W_LSB     = lbcp_pkg::W_LSB;
   localparam int H_LSB     = lbcp_pkg::H_LSB;
   localparam int Z_LSB     = lbcp_pkg::Z_LSB;
   localparam int L_LSB     = lbcp_pkg::L_LSB;

   typedef struct packed {
      logic                 pair_found;
      logic [IDX_OUT_W-1:0] earlier;
      logic [IDX_OUT_W-1:0] newer;
      logic                 dropped;
      logic                 closing;
   } pair_result_type;

   logic signed [COORD_W-1:0] slot_left   [MAX_BOXES];
   logic signed [COORD_W-1:0] slot_top    [MAX_BOXES];
   logic signed [COORD_W-1:0] slot_depth  [MAX_BOXES];
   logic [SIZE_W-1:0]         slot_width  [MAX_BOXES];
   logic [SIZE_W-1:0]         slot_height [MAX_BOXES];
   logic [LAYER_W-1:0]        slot_layer  [MAX_BOXES];
   int                        boxes_held;
   logic [MATRIX_W-1:0]       layer_matrix;
   logic [TOL_W-1:0]          depth_tolerance;
   pair_result_type           expected_pairs[$];

   function automatic int magnitude(int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic void predict_pairs(logic [lbcp_pkg::BOX_W-1:0] box, logic restart);
      int nx, ny, nw, nh, nz, sx, sy, sw, sh, sz;
      logic [LAYER_W-1:0] nl;
      int hits;
      int hit_slot [MAX_BOXES];
      pair_result_type r;
      nx = int'($signed(box[X_LSB +: COORD_W]));
      ny = int'($signed(box[Y_LSB +: COORD_W]));
      nw = int'(box[W_LSB +: SIZE_W]);
      nh = int'(box[H_LSB +: SIZE_W]);
      nz = int'($signed(box[Z_LSB +: COORD_W]));
      nl = box[L_LSB +: LAYER_W];
      hits = 0;
      if (restart) boxes_held = 0;
      r = '0;
      if (boxes_held >= MAX_BOXES) begin
         r.dropped = 1'b1;
         r.closing = 1'b1;
         expected_pairs.insert(expected_pairs.size(), r);
         return;
      end
      for (int i = 0; i < boxes_held; i++) begin
         sx = slot_left[i];
         sy = slot_top[i];
         sw = int'(slot_width[i]);
         sh = int'(slot_height[i]);
         sz = slot_depth[i];
         // touching edges count as overlap; depth test is one-sided
         if (layer_matrix[{slot_layer[i], nl}] &&
             (magnitude(sz) - magnitude(nz)) <= int'(depth_tolerance) &&
             !((sx + sw) < nx || (nx + nw) < sx || (ny + nh) < sy || (sy + sh) < ny)) begin
            hit_slot[hits] = i;
            hits++;
         end
      end
      r.newer = IDX_OUT_W'(boxes_held);
      if (hits == 0) begin
         r.closing = 1'b1;
         expected_pairs.insert(expected_pairs.size(), r);
      end else begin
         r.pair_found = 1'b1;
         for (int k = 0; k < hits; k++) begin
            r.earlier = IDX_OUT_W'(hit_slot[k]);
            r.closing = (k == hits - 1);
            expected_pairs.insert(expected_pairs.size(), r);
         end
      end
      slot_left[boxes_held]   = box[X_LSB +: COORD_W];
      slot_top[boxes_held]    = box[Y_LSB +: COORD_W];
      slot_width[boxes_held]  = box[W_LSB +: SIZE_W];
      slot_height[boxes_held] = box[H_LSB +: SIZE_W];
      slot_depth[boxes_held]  = box[Z_LSB +: COORD_W];
      slot_layer[boxes_held]  = nl;
      boxes_held++;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatches++;
      if (mismatches <= 40)
         $display("%0t: %s is %0d, expected %0d", $time, what, got, want);
   endtask

   task automatic check_result();
      pair_result_type want;
      results_seen++;
      if (rsp_tuser[0]) pairs_seen++;
      if (rsp_tuser[1]) drops_seen++;
      if (expected_pairs.size() == 0) begin
         report_mismatch("result with nothing pending, newer_index",
                         rsp_tdata[2*IDX_OUT_W-1:IDX_OUT_W], -1);
         return;
      end
      want = expected_pairs.pop_front();
      if (rsp_tuser[0] !== want.pair_found)
         report_mismatch("pair_found", rsp_tuser[0], want.pair_found);
      if (rsp_tdata[IDX_OUT_W-1:0] !== want.earlier)
         report_mismatch("earlier_index", rsp_tdata[IDX_OUT_W-1:0], want.earlier);
      if (rsp_tdata[2*IDX_OUT_W-1:IDX_OUT_W] !== want.newer)
         report_mismatch("newer_index", rsp_tdata[2*IDX_OUT_W-1:IDX_OUT_W], want.newer);
      if (rsp_tuser[1] !== want.dropped)
         report_mismatch("dropped", rsp_tuser[1], want.dropped);
      if (rsp_tlast !== want.closing)
         report_mismatch("last_result", rsp_tlast, want.closing);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_pairs.delete();
         boxes_held      = 0;
         layer_matrix    = lbcp_pkg::LAYER_MATRIX_RST;
         depth_tolerance = lbcp_pkg::DEPTH_TOL_RST;
         mismatches      = 0;
         results_seen    = 0;
         pairs_seen      = 0;
         drops_seen      = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               lbcp_pkg::CSR_LAYER_MATRIX: layer_matrix = csr_data[MATRIX_W-1:0];
               lbcp_pkg::CSR_DEPTH_TOL:    depth_tolerance = csr_data[TOL_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) check_result();
         if (req_tvalid && req_tready) predict_pairs(req_tdata, req_tuser[0]);
      end
      pending <= expected_pairs.size();
   end

endmodule

>>> verif/layered_box_collision_pairs_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// layered_box_collision_pairs_test
// Drives frames of boxes into the collision pair finder under several layer
// matrix and depth tolerance settings, with random gaps on both sides and one
// long result stall. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module layered_box_collision_pairs_test;

   localparam int HOLD_CYCLES = 300;
   localparam int IDLE_LIMIT  = 3000;

   localparam int BOX_W      = lbcp_pkg::BOX_W;
   localparam int REQ_USER_W = lbcp_pkg::REQ_USER_W;
   localparam int RSP_DATA_W = lbcp_pkg::RSP_DATA_W;
   localparam int RSP_USER_W = lbcp_pkg::RSP_USER_W;
   localparam int CSR_IDX_W  = lbcp_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = lbcp_pkg::CSR_DATA_W;
   localparam int COORD_W    = lbcp_pkg::COORD_W;
   localparam int SIZE_W     = lbcp_pkg::SIZE_W;
   localparam int LAYER_W    = lbcp_pkg::LAYER_W;
   localparam int MATRIX_W   = lbcp_pkg::MATRIX_W;
   localparam int TOL_W      = lbcp_pkg::TOL_W;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [BOX_W-1:0]       req_tdata;
   logic [REQ_USER_W-1:0]  req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [RSP_USER_W-1:0]  rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   logic hold_request;
   bit   quiet = 1'b0;
   int   boxes_sent = 0;
   int   idle_cycles;
   int   mismatches, pending, results_seen, pairs_seen, drops_seen;

   layered_box_collision_pairs #(.MAX_BOXES(32)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   layered_box_collision_pairs_checker #(.MAX_BOXES(32)) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .mismatches   (mismatches),
      .pending      (pending),
      .results_seen (results_seen),
      .pairs_seen   (pairs_seen),
      .drops_seen   (drops_seen)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("layered_box_collision_pairs_test: done, errors");
      $finish;
   end

   // result side: random back-pressure, plus one long hold on request
   initial begin
      bit held;
      held = 1'b0;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         @(posedge clock);
         if (hold_request && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= quiet || ($urandom_range(99) >= 12);
         end
      end
   end

   task automatic send_box(input logic restart, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y, input logic [SIZE_W-1:0] w,
                           input logic [SIZE_W-1:0] h, input logic [COORD_W-1:0] z,
                           input logic [LAYER_W-1:0] layer);
      if (!quiet && $urandom_range(99) < 12) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while (!quiet && $urandom_range(99) < 12);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= restart;
      req_tdata  <= {layer, z, h, w, y, x};
      do @(posedge clock); while (!req_tready);
      boxes_sent++;
   endtask

   // most boxes land in a small arena so that pairs are common
   task automatic send_random(input logic restart, input bit wide);
      if (wide)
         send_box(restart, COORD_W'($urandom), COORD_W'($urandom), SIZE_W'($urandom),
                  SIZE_W'($urandom), COORD_W'($urandom), LAYER_W'($urandom));
      else
         send_box(restart, COORD_W'($urandom_range(80) - 40),
                  COORD_W'($urandom_range(80) - 40), SIZE_W'($urandom_range(40)),
                  SIZE_W'($urandom_range(40)), COORD_W'($urandom_range(24) - 12),
                  LAYER_W'($urandom));
   endtask

   task automatic send_frames(input int count, input int wide_pct);
      int left, frame_len;
      left = count;
      while (left > 0) begin
         frame_len = ($urandom_range(7) == 0) ? 34 : $urandom_range(1, 12);
         for (int k = 0; k < frame_len && left > 0; k++) begin
            send_random(k == 0, $urandom_range(99) < wide_pct);
            left--;
         end
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(input logic [MATRIX_W-1:0] matrix,
                             input logic [TOL_W-1:0] tol);
      csr_valid <= 1'b1;
      csr_index <= lbcp_pkg::CSR_LAYER_MATRIX;
      csr_data  <= CSR_DATA_W'(matrix);
      do @(posedge clock); while (!csr_ready);
      csr_index <= lbcp_pkg::CSR_DEPTH_TOL;
      csr_data  <= CSR_DATA_W'(tol);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      req_tuser    <= '0;
      csr_valid    <= 1'b0;
      csr_index    <= lbcp_pkg::CSR_LAYER_MATRIX;
      csr_data     <= '0;
      hold_request <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: layers 0-2 partly open, layer 3 closed, tolerance 3
      send_box(1'b1, 16'sd0, 16'sd0, 15'd10, 15'd10, 16'sd0, 2'd1);
      send_box(1'b0, 16'sd10, 16'sd0, 15'd5, 15'd5, 16'sd0, 2'd0);    // edge touch
      send_box(1'b0, 16'sd16, 16'sd0, 15'd5, 15'd5, 16'sd0, 2'd0);    // one pixel apart
      send_box(1'b0, 16'sd0, 16'sd0, 15'd20, 15'd20, 16'sd10, 2'd2);
      send_box(1'b0, 16'sd0, 16'sd0, 15'd20, 15'd20, 16'sd0, 2'd2);   // depth too far
      send_box(1'b0, 16'sd0, 16'sd0, 15'd20, 15'd20, -16'sd7, 2'd2);  // depth at limit
      send_box(1'b0, 16'sd0, 16'sd20, 15'd5, 15'd5, 16'sd0, 2'd1);
      send_box(1'b0, 16'sd0, 16'sd21, 15'd5, 15'd5, 16'sd0, 2'd1);
      send_box(1'b0, 16'sd0, 16'sd0, 15'h7FFF, 15'h7FFF, 16'sd0, 2'd3);
      send_box(1'b0, 16'sd0, 16'sd0, 15'd40, 15'd40, 16'sd0, 2'd0);
      send_box(1'b0, 16'h8000, 16'h8000, 15'd0, 15'd0, 16'h8000, 2'd0);
      send_box(1'b0, 16'h7FFF, 16'h7FFF, 15'h7FFF, 15'h7FFF, 16'h7FFF, 2'd1);
      send_box(1'b0, 16'h8000, 16'h7FFF, 15'h7FFF, 15'd0, 16'h7FFF, 2'd2);
      send_box(1'b1, 16'sd5, 16'sd5, 15'd0, 15'd0, 16'sd0, 2'd1);       // new frame
      send_box(1'b0, 16'sd5, 16'sd5, 15'd0, 15'd0, 16'sd0, 2'd0);
      send_box(1'b0, -16'sd3, 16'sd5, 15'd8, 15'd0, -16'sd3, 2'd2);

      // everything open: a pile-up frame fills the store and overflows it
      settle();
      set_config(16'hFFFF, 8'd255);
      for (int k = 0; k < 34; k++) begin
         if (k == 20) hold_request <= 1'b1;
         send_box(k == 0, COORD_W'($urandom_range(8) - 4), COORD_W'($urandom_range(8) - 4),
                  SIZE_W'($urandom_range(8, 16)), SIZE_W'($urandom_range(8, 16)),
                  COORD_W'($urandom_range(200) - 100), LAYER_W'($urandom));
      end

      settle();
      set_config(16'h0000, 8'd0);
      send_frames(20, 0);

      settle();
      quiet = 1'b1;
      set_config(MATRIX_W'($urandom), TOL_W'($urandom));
      send_frames(30, 20);
      settle();
      quiet = 1'b0;

      repeat (3) begin
         set_config(MATRIX_W'($urandom), TOL_W'($urandom));
         send_frames(25, 20);
         settle();
      end
      repeat (40) @(posedge clock);

      $display("%0d boxes sent, %0d results checked: %0d colliding pairs, %0d dropped boxes",
               boxes_sent, results_seen, pairs_seen, drops_seen);
      $display("settings: reset, all open, all closed, four random; one %0d-cycle stall",
               HOLD_CYCLES);
      if (mismatches == 0)
         $display("layered_box_collision_pairs_test: done, clean");
      else
         $display("layered_box_collision_pairs_test: done, errors");
      $finish;
   end

endmodule
